### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition leads to another one on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/slb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slb_pkg
// Types, constants and helpers of the stop trigger book.
// ---------------------------------------------------------------------------
package slb_pkg;

    localparam int SYMBOLS        = 64;
    localparam int STOPS_PER_SIDE = 16;
    localparam int MAX_RESULTS    = 32;

    localparam int SYM_W   = 6;
    localparam int PRICE_W = 32;
    localparam int ID_W    = 48;
    localparam int KIND_W  = 2;
    localparam int Q_W     = SYM_W + 1;
    localparam int CNT_W   = $clog2(STOPS_PER_SIDE + 1);
    localparam int RES_W   = $clog2(MAX_RESULTS + 1);
    localparam int DEPTH   = 2 * SYMBOLS * STOPS_PER_SIDE;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_PRICE    = 1'b1;

    localparam logic [KIND_W-1:0] KIND_TRIG   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STORED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    typedef struct packed {
        logic [PRICE_W-1:0] trig;
        logic [PRICE_W-1:0] lim;
        logic [PRICE_W-1:0] qty;
        logic [ID_W-1:0]    cli;
        logic [ID_W-1:0]    trd;
    } entry_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ID_W-1:0]    assigned_id;
        logic [ID_W-1:0]    cli;
        logic [ID_W-1:0]    trd;
        logic               side;
        logic [PRICE_W-1:0] lim;
        logic [PRICE_W-1:0] qty;
        logic [SYM_W-1:0]   sym;
        logic [ID_W-1:0]    otime;
        logic               last;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_META,
        S_DECIDE,
        S_SCAN,
        S_FIRE,
        S_SHRD,
        S_SHWR,
        S_CNTWR,
        S_CNTRD,
        S_CNTLD,
        S_FINAL
    } state_t;

    typedef struct packed {
        logic accept;
        logic cnt_rd;
        logic meta_rd;
        logic decide;
        logic scan_step;
        logic fire;
        logic sh_rd;
        logic sh_wr;
        logic cnt_wr;
        logic buy_side;
        logic cnt_ld;
        logic final_push;
    } dp_cmd_t;

    typedef struct packed {
        logic is_price;
        logic price_go;
        logic scan_done;
        logic found_ok;
        logic fire_go;
        logic shift_more;
        logic side_sell;
        logic out_free;
    } dp_stat_t;

    // Slot address of one stop within its symbol and side
    function automatic logic [ADDR_W-1:0] stop_addr(input logic [Q_W-1:0] q,
                                                    input logic [CNT_W-1:0] slot);
        return ADDR_W'(int'(q) * STOPS_PER_SIDE + int'(slot));
    endfunction

endpackage

### rtl/slb_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slb_ctrl
// Sequencer of the stop trigger book: steps register, scan, fire and shift.
// ---------------------------------------------------------------------------
module slb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  slb_pkg::dp_stat_t stat,
    output slb_pkg::dp_cmd_t  cmd
);
    import slb_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_META;
                end
            end
            S_META:   state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (stat.is_price && stat.price_go)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (stat.found_ok)
                    begin
                        state_next = S_FIRE;
                    end
                    else if (stat.side_sell)
                    begin
                        state_next = S_CNTRD;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_FIRE:
            begin
                if (stat.fire_go)
                begin
                    state_next = S_SHRD;
                end
            end
            S_SHRD:
            begin
                if (stat.shift_more)
                begin
                    state_next = S_SHWR;
                end
                else
                begin
                    state_next = S_CNTWR;
                end
            end
            S_SHWR:   state_next = S_SHRD;
            S_CNTWR:  state_next = S_SCAN;
            S_CNTRD:  state_next = S_CNTLD;
            S_CNTLD:  state_next = S_SCAN;
            S_FINAL:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            S_META:
            begin
                cmd.cnt_rd  = 1'b1;
                cmd.meta_rd = 1'b1;
            end
            S_DECIDE: cmd.decide = 1'b1;
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.buy_side  = stat.scan_done && !stat.found_ok && stat.side_sell;
            end
            S_FIRE:   cmd.fire = stat.fire_go;
            S_SHRD:   cmd.sh_rd = 1'b1;
            S_SHWR:   cmd.sh_wr = 1'b1;
            S_CNTWR:  cmd.cnt_wr = 1'b1;
            S_CNTRD:  cmd.cnt_rd = 1'b1;
            S_CNTLD:  cmd.cnt_ld = 1'b1;
            S_FINAL:  cmd.final_push = stat.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

### rtl/slb_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slb_dp
// Datapath: stop memory, count and last-price stores, scan and output regs.
// ---------------------------------------------------------------------------
module slb_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  slb_pkg::dp_cmd_t             cmd,
    output slb_pkg::dp_stat_t            stat,
    input  logic                         command,
    input  logic [slb_pkg::SYM_W-1:0]    symbol,
    input  logic                         side,
    input  logic [slb_pkg::PRICE_W-1:0]  stop_price,
    input  logic [slb_pkg::PRICE_W-1:0]  limit_price,
    input  logic [slb_pkg::PRICE_W-1:0]  quantity,
    input  logic [slb_pkg::ID_W-1:0]     client_ref,
    input  logic [slb_pkg::ID_W-1:0]     trader_ref,
    input  logic [slb_pkg::PRICE_W-1:0]  market_price,
    input  logic [slb_pkg::ID_W-1:0]     timestamp,
    input  logic                         cfg_wr,
    input  logic [slb_pkg::ID_W-1:0]     cfg_data,
    input  logic                         out_stall,
    output logic                         out_valid,
    output slb_pkg::res_t                out_res
);
    import slb_pkg::*;

    // Captured item
    logic               cmd_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic               side_sel_reg;
    entry_t             new_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [ID_W-1:0]    ts_reg;

    // Scan state
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [CNT_W-1:0]   best_pos_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic [CNT_W-1:0]   cnt_rd_reg;
    logic [PRICE_W-1:0] seen_rd_reg;
    entry_t             rd_data_reg;
    entry_t             best_reg;
    logic               rd_pend_reg;
    logic               found_reg;
    logic [RES_W-1:0]   res_cnt_reg;
    logic [ID_W-1:0]    next_order_reg;
    logic [ID_W-1:0]    next_order_next;

    // Result staging
    res_t               pend_reg;
    logic               pend_vld_reg;
    res_t               out_reg;
    logic               out_valid_reg;

    // Stores
    entry_t             stop_mem [DEPTH];
    logic [CNT_W-1:0]   cnt_mem  [2*SYMBOLS];
    logic [2*SYMBOLS-1:0] cnt_vld_reg;
    logic [PRICE_W-1:0] seen_mem [SYMBOLS];
    logic [SYMBOLS-1:0] seen_vld_reg;

    logic [Q_W-1:0]     q;
    logic               sym_ok;
    logic               reg_ok;
    logic               price_go;
    logic               out_free;
    logic               shift_more;
    logic [CNT_W-1:0]   k_inc;
    logic               hit;
    logic               better;
    logic               take;
    logic               do_store;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    entry_t             mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic               cnt_we;
    logic [CNT_W-1:0]   cnt_wdata;
    res_t               trig_res;
    res_t               final_res;

    function automatic res_t plain_res(input logic [KIND_W-1:0] kind,
                                       input logic [SYM_W-1:0] sym,
                                       input logic sd);
        res_t r;
        r      = '0;
        r.kind = kind;
        r.sym  = sym;
        r.side = sd;
        return r;
    endfunction

    // Work out status and datapath selects
    assign q          = {sym_reg, side_sel_reg};
    assign sym_ok     = 32'(sym_reg) < 32'(SYMBOLS);
    assign reg_ok     = sym_ok && (cnt_rd_reg < CNT_W'(STOPS_PER_SIDE));
    assign price_go   = sym_ok && (price_reg != seen_rd_reg);
    assign out_free   = !out_valid_reg || !out_stall;
    assign k_inc      = k_reg + CNT_W'(1);
    assign shift_more = ({1'b0, k_reg} + (CNT_W+1)'(1)) < {1'b0, n_reg};
    assign do_store   = cmd.decide && (cmd_reg == CMD_REGISTER) && reg_ok;

    assign hit    = side_sel_reg ? (price_reg <= rd_data_reg.trig)
                                 : (price_reg >= rd_data_reg.trig);
    assign better = !found_reg || (side_sel_reg ? (rd_data_reg.trig > best_reg.trig)
                                                : (rd_data_reg.trig < best_reg.trig));
    assign take   = cmd.scan_step && rd_pend_reg && hit && better;

    always_comb
    begin
        stat.is_price   = (cmd_reg == CMD_PRICE);
        stat.price_go   = price_go;
        stat.scan_done  = (k_reg == n_reg) && !rd_pend_reg;
        stat.found_ok   = found_reg && (res_cnt_reg < RES_W'(MAX_RESULTS));
        stat.fire_go    = !pend_vld_reg || out_free;
        stat.shift_more = shift_more;
        stat.side_sell  = side_sel_reg;
        stat.out_free   = out_free;
    end

    // Select memory and count store ports
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = stop_addr(q, cnt_rd_reg);
        mem_wdata = new_reg;
        if (do_store)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.sh_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = stop_addr(q, k_reg);
            mem_wdata = rd_data_reg;
        end

        mem_re    = 1'b0;
        mem_raddr = stop_addr(q, k_reg);
        if (cmd.scan_step && (k_reg != n_reg))
        begin
            mem_re = 1'b1;
        end
        else if (cmd.sh_rd && shift_more)
        begin
            mem_re    = 1'b1;
            mem_raddr = stop_addr(q, k_inc);
        end

        cnt_we    = 1'b0;
        cnt_wdata = cnt_rd_reg + CNT_W'(1);
        if (do_store)
        begin
            cnt_we = 1'b1;
        end
        else if (cmd.cnt_wr)
        begin
            cnt_we    = 1'b1;
            cnt_wdata = n_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        trig_res             = '0;
        trig_res.kind        = KIND_TRIG;
        trig_res.assigned_id = next_order_reg;
        trig_res.cli         = best_reg.cli;
        trig_res.trd         = best_reg.trd;
        trig_res.side        = side_sel_reg;
        trig_res.lim         = best_reg.lim;
        trig_res.qty         = best_reg.qty;
        trig_res.sym         = sym_reg;
        trig_res.otime       = ts_reg;
        trig_res.last        = 1'b0;
    end

    // Close the item with the staged result, or with a plain one
    always_comb
    begin
        final_res      = pend_vld_reg ? pend_reg : plain_res(KIND_NONE, sym_reg, 1'b0);
        final_res.last = 1'b1;
    end

    // Stop memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stop_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= stop_mem[mem_raddr];
        end
    end

    // Count and last-price stores
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[q] <= cnt_wdata;
        end
        if (cmd.cnt_rd)
        begin
            cnt_rd_reg <= cnt_vld_reg[q] ? cnt_mem[q] : '0;
        end
        if (cmd.decide && (cmd_reg == CMD_PRICE) && price_go)
        begin
            seen_mem[sym_reg] <= price_reg;
        end
        if (cmd.meta_rd)
        begin
            seen_rd_reg <= seen_vld_reg[sym_reg] ? seen_mem[sym_reg] : '0;
        end
    end

    // Clear store valid bits at reset, set on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg  <= '0;
            seen_vld_reg <= '0;
        end
        else
        begin
            if (cnt_we)
            begin
                cnt_vld_reg[q] <= 1'b1;
            end
            if (cmd.decide && (cmd_reg == CMD_PRICE) && price_go)
            begin
                seen_vld_reg[sym_reg] <= 1'b1;
            end
        end
    end

    // Order id counter
    always_comb
    begin
        next_order_next = next_order_reg;
        if (cfg_wr)
        begin
            next_order_next = cfg_data;
        end
        else if (cmd.fire)
        begin
            next_order_next = next_order_reg + ID_W'(1);
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_order_reg <= ID_W'(1);
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            pend_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            side_sel_reg   <= 1'b0;
            cmd_reg        <= CMD_REGISTER;
            res_cnt_reg    <= '0;
            n_reg          <= '0;
            k_reg          <= '0;
        end
        else
        begin
            next_order_reg <= next_order_next;

            if (cmd.accept)
            begin
                cmd_reg      <= command;
                side_sel_reg <= (command == CMD_PRICE) ? 1'b1 : side;
                res_cnt_reg  <= '0;
                pend_vld_reg <= 1'b0;
            end
            if (cmd.buy_side)
            begin
                side_sel_reg <= 1'b0;
            end

            // Start a scan of one side
            if ((cmd.decide && (cmd_reg == CMD_PRICE) && price_go) || cmd.cnt_ld)
            begin
                n_reg       <= cnt_rd_reg;
                k_reg       <= '0;
                found_reg   <= 1'b0;
                rd_pend_reg <= 1'b0;
            end
            if (do_store)
            begin
                pend_vld_reg <= 1'b1;
            end
            else if (cmd.decide && (cmd_reg == CMD_REGISTER))
            begin
                pend_vld_reg <= 1'b1;
            end

            // Walk the side, one slot a cycle
            if (cmd.scan_step)
            begin
                rd_pend_reg <= (k_reg != n_reg);
                if (k_reg != n_reg)
                begin
                    k_reg <= k_inc;
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end

            // Fire the best stop and start closing the gap
            if (cmd.fire)
            begin
                pend_vld_reg <= 1'b1;
                k_reg        <= best_pos_reg;
                res_cnt_reg  <= res_cnt_reg + RES_W'(1);
            end
            if (cmd.sh_wr)
            begin
                k_reg <= k_inc;
            end
            if (cmd.cnt_wr)
            begin
                n_reg       <= n_reg - CNT_W'(1);
                k_reg       <= '0;
                found_reg   <= 1'b0;
                rd_pend_reg <= 1'b0;
            end

            // Output register
            if (cmd.final_push || (cmd.fire && pend_vld_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.final_push)
            begin
                pend_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sym_reg       <= symbol;
            new_reg.trig  <= stop_price;
            new_reg.lim   <= limit_price;
            new_reg.qty   <= quantity;
            new_reg.cli   <= client_ref;
            new_reg.trd   <= trader_ref;
            price_reg     <= market_price;
            ts_reg        <= timestamp;
        end
        if (cmd.scan_step && rd_pend_reg)
        begin
            if (take)
            begin
                best_reg     <= rd_data_reg;
                best_pos_reg <= rd_idx_reg;
            end
        end
        if (cmd.scan_step)
        begin
            rd_idx_reg <= k_reg;
        end
        if (cmd.decide && (cmd_reg == CMD_REGISTER))
        begin
            pend_reg <= plain_res(reg_ok ? KIND_STORED : KIND_REJECT, sym_reg, side_sel_reg);
        end
        if (cmd.fire)
        begin
            pend_reg <= trig_res;
            if (pend_vld_reg)
            begin
                out_reg <= pend_reg;
            end
        end
        if (cmd.final_push)
        begin
            out_reg <= final_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

### rtl/stop_loss_trigger_book.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stop_loss_trigger_book
// Per-symbol book of pending buy and sell stops, fired by price updates.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command item: register
//   a stop or a market price update. Output channel (out_valid / out_stall)
//   carries result items; the final one of each input has last set.
//   cfg_valid / cfg_ready loads the first order id; cfg_ready is always high.
// Flow: one item is worked on at a time around one read port and one
//   write port of the stop memory. A register or an unchanged price passes
//   through the meta, decide and final states before the next item is taken.
//   A changed price also scans the sell side and then the buy side; each
//   fired stop is issued, the gap behind it is closed, and the stops left
//   on that side are scanned afresh.
// Reset: all stores read empty, last prices read zero, order ids restart
//   at 1. No clearing pass is needed; valid bits cover counts and prices.
// Stall: a result waits in the output register; one more is staged behind
//   it, after which the sequencer holds until the receiver takes the item.
// ---------------------------------------------------------------------------
module stop_loss_trigger_book (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         command,
    input  logic [slb_pkg::SYM_W-1:0]    symbol,
    input  logic                         side,
    input  logic [slb_pkg::PRICE_W-1:0]  stop_price,
    input  logic [slb_pkg::PRICE_W-1:0]  limit_price,
    input  logic [slb_pkg::PRICE_W-1:0]  quantity,
    input  logic [slb_pkg::ID_W-1:0]     client_ref,
    input  logic [slb_pkg::ID_W-1:0]     trader_ref,
    input  logic [slb_pkg::PRICE_W-1:0]  market_price,
    input  logic [slb_pkg::ID_W-1:0]     timestamp,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [slb_pkg::KIND_W-1:0]   kind,
    output logic [slb_pkg::ID_W-1:0]     assigned_id,
    output logic [slb_pkg::ID_W-1:0]     client_order_id_res,
    output logic [slb_pkg::ID_W-1:0]     trader_id_res,
    output logic                         side_res,
    output logic [slb_pkg::PRICE_W-1:0]  limit_price_res,
    output logic [slb_pkg::PRICE_W-1:0]  quantity_res,
    output logic [slb_pkg::SYM_W-1:0]    symbol_res,
    output logic [slb_pkg::ID_W-1:0]     order_time,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [slb_pkg::ID_W-1:0]     cfg_data
);
    import slb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    res_t     res;

    assign cfg_ready = 1'b1;

    slb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    slb_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .command         (command),
        .symbol          (symbol),
        .side            (side),
        .stop_price      (stop_price),
        .limit_price     (limit_price),
        .quantity        (quantity),
        .client_ref      (client_ref),
        .trader_ref      (trader_ref),
        .market_price    (market_price),
        .timestamp       (timestamp),
        .cfg_wr          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .out_res         (res)
    );

    // Unpack the result item
    assign kind                = res.kind;
    assign assigned_id         = res.assigned_id;
    assign client_order_id_res = res.cli;
    assign trader_id_res       = res.trd;
    assign side_res            = res.side;
    assign limit_price_res     = res.lim;
    assign quantity_res        = res.qty;
    assign symbol_res          = res.sym;
    assign order_time          = res.otime;
    assign last                = res.last;

endmodule

### rtl/slb_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slb_check
// Port-level checks of the stop trigger book, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slb_check (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [slb_pkg::KIND_W-1:0]   kind,
    input logic [slb_pkg::ID_W-1:0]     assigned_id,
    input logic                         last
);
    import slb_pkg::*;

    logic plain_out;

    assign plain_out = out_valid && (kind != KIND_TRIG);

    // A stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")

    // An accepted item keeps the block busy on the next cycle
    `ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while busy")

    // Only triggered orders can be followed by more results of the same item
    `ASSERT_IMPLY(a_last, clk, rst_n, plain_out, last, "plain result not last")

    // Plain results carry no order id
    `ASSERT_IMPLY(a_noid, clk, rst_n, plain_out, assigned_id == '0, "plain result has id")

endmodule

bind stop_loss_trigger_book slb_check u_slb_check (.*);

### tb/sv/stop_loss_trigger_book_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stop_loss_trigger_book_checker
// Watches the command, result and order id load channels of the stop book.
// It keeps its own copy of the book, works out the result items of every
// accepted command and compares each accepted result with the oldest one.
// ---------------------------------------------------------------------------
module stop_loss_trigger_book_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        command,
    input  logic [slb_pkg::SYM_W-1:0]   symbol,
    input  logic                        side,
    input  logic [slb_pkg::PRICE_W-1:0] stop_price,
    input  logic [slb_pkg::PRICE_W-1:0] limit_price,
    input  logic [slb_pkg::PRICE_W-1:0] quantity,
    input  logic [slb_pkg::ID_W-1:0]    client_ref,
    input  logic [slb_pkg::ID_W-1:0]    trader_ref,
    input  logic [slb_pkg::PRICE_W-1:0] market_price,
    input  logic [slb_pkg::ID_W-1:0]    timestamp,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [slb_pkg::KIND_W-1:0]  kind,
    input  logic [slb_pkg::ID_W-1:0]    assigned_id,
    input  logic [slb_pkg::ID_W-1:0]    client_order_id_res,
    input  logic [slb_pkg::ID_W-1:0]    trader_id_res,
    input  logic                        side_res,
    input  logic [slb_pkg::PRICE_W-1:0] limit_price_res,
    input  logic [slb_pkg::PRICE_W-1:0] quantity_res,
    input  logic [slb_pkg::SYM_W-1:0]   symbol_res,
    input  logic [slb_pkg::ID_W-1:0]    order_time,
    input  logic                        last,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [slb_pkg::ID_W-1:0]    cfg_data,
    output int                          fail_count,
    output int                          pending,
    output int                          fired_total
);
    import slb_pkg::*;

    // Book copy: one pending list per symbol and side, kept in arrival order
    entry_t     book [SYMBOLS*2][$];
    logic [PRICE_W-1:0] seen_copy [SYMBOLS];
    logic [ID_W-1:0]    id_counter;
    res_t       due_results [$];

    function automatic res_t plain_result(logic [KIND_W-1:0] k, logic [SYM_W-1:0] s,
                                          logic sd);
        res_t r;
        r = '0;
        r.kind = k;
        r.sym  = s;
        r.side = sd;
        r.last = 1'b1;
        return r;
    endfunction

    // Work out the result items of one accepted command
    task automatic book_command();
        int     q;
        int     best;
        int     fired;
        logic   sd;
        res_t   r;
        entry_t e;
        fired = 0;
        if (command == CMD_REGISTER)
        begin
            q = int'(symbol) * 2 + int'(side);
            if (book[q].size() >= STOPS_PER_SIDE)
                due_results = {due_results, plain_result(KIND_REJECT, symbol, side)};
            else
            begin
                e = '{stop_price, limit_price, quantity, client_ref, trader_ref};
                book[q] = {book[q], e};
                due_results = {due_results, plain_result(KIND_STORED, symbol, side)};
            end
            return;
        end
        if (market_price != seen_copy[symbol])
        begin
            // Sell stops first, highest trigger; then buy stops, lowest trigger
            for (int pass = 0; pass < 2; pass++)
            begin
                sd = (pass == 0);
                q  = int'(symbol) * 2 + int'(sd);
                while (fired < MAX_RESULTS)
                begin
                    best = -1;
                    foreach (book[q][k])
                    begin
                        if (sd ? (market_price <= book[q][k].trig)
                               : (market_price >= book[q][k].trig))
                        begin
                            if (best < 0)
                                best = k;
                            else if (sd ? (book[q][k].trig > book[q][best].trig)
                                        : (book[q][k].trig < book[q][best].trig))
                                best = k;
                        end
                    end
                    if (best < 0)
                        break;
                    r = '0;
                    r.kind        = KIND_TRIG;
                    r.assigned_id = id_counter;
                    r.cli         = book[q][best].cli;
                    r.trd         = book[q][best].trd;
                    r.side        = sd;
                    r.lim         = book[q][best].lim;
                    r.qty         = book[q][best].qty;
                    r.sym         = symbol;
                    r.otime       = timestamp;
                    id_counter    = id_counter + ID_W'(1);
                    book[q].delete(best);
                    due_results = {due_results, r};
                    fired++;
                end
            end
            seen_copy[symbol] = market_price;
        end
        if (fired == 0)
            due_results = {due_results, plain_result(KIND_NONE, symbol, 1'b0)};
        else
            due_results[$].last = 1'b1;
        fired_total += fired;
    endtask

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Advance the book on every accepted item, compare every result item
    always @(posedge clk or negedge rst_n)
    begin
        res_t w;
        if (!rst_n)
        begin
            foreach (book[i]) book[i].delete();
            foreach (seen_copy[i]) seen_copy[i] = '0;
            id_counter  = ID_W'(1);
            due_results.delete();
            fail_count  = 0;
            fired_total = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                id_counter = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fail_count++;
                end
                else
                begin
                    w = due_results.pop_front();
                    compare_field("kind", w.kind, kind);
                    compare_field("assigned_id", w.assigned_id, assigned_id);
                    compare_field("client_order_id_res", w.cli, client_order_id_res);
                    compare_field("trader_id_res", w.trd, trader_id_res);
                    compare_field("side_res", w.side, side_res);
                    compare_field("limit_price_res", w.lim, limit_price_res);
                    compare_field("quantity_res", w.qty, quantity_res);
                    compare_field("symbol_res", w.sym, symbol_res);
                    compare_field("order_time", w.otime, order_time);
                    compare_field("last", w.last, last);
                end
            end
            if (in_valid && !in_stall)
                book_command();
            pending = due_results.size();
        end
    end

endmodule

### tb/sv/stop_loss_trigger_book_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stop_loss_trigger_book_test
// Drives stop registrations and price updates into the stop book with random
// gaps and output stalls, reloads the first order id between phases, and
// reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module stop_loss_trigger_book_test;
    import slb_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               command;
    logic [SYM_W-1:0]   symbol;
    logic               side;
    logic [PRICE_W-1:0] stop_price;
    logic [PRICE_W-1:0] limit_price;
    logic [PRICE_W-1:0] quantity;
    logic [ID_W-1:0]    client_ref;
    logic [ID_W-1:0]    trader_ref;
    logic [PRICE_W-1:0] market_price;
    logic [ID_W-1:0]    timestamp;
    logic               out_valid;
    logic               out_stall;
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    assigned_id;
    logic [ID_W-1:0]    client_order_id_res;
    logic [ID_W-1:0]    trader_id_res;
    logic               side_res;
    logic [PRICE_W-1:0] limit_price_res;
    logic [PRICE_W-1:0] quantity_res;
    logic [SYM_W-1:0]   symbol_res;
    logic [ID_W-1:0]    order_time;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [ID_W-1:0]    cfg_data;
    int                 fail_count;
    int                 pending;
    int                 fired_total;
    int                 sent;
    logic               calm;

    stop_loss_trigger_book u_top (.*);
    stop_loss_trigger_book_checker u_check (.*);

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold off the receiver for a random count of cycles per item
    initial
    begin
        int gap;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Present one item and wait until it is taken
    task automatic send_item(logic cmd, logic [SYM_W-1:0] sym, logic sd,
                             logic [PRICE_W-1:0] trig, logic [PRICE_W-1:0] mkt);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command      <= cmd;
        symbol       <= sym;
        side         <= sd;
        stop_price   <= trig;
        limit_price  <= $urandom;
        quantity     <= $urandom;
        client_ref   <= ID_W'({$urandom, $urandom} >> 16);
        trader_ref   <= ID_W'({$urandom, $urandom} >> 16);
        market_price <= mkt;
        timestamp    <= ID_W'({$urandom, $urandom} >> 16);
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    // Drain every expected result, then load a new first order id
    task automatic load_first_id(logic [ID_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random price near a narrow band so stops fire often
    function automatic logic [PRICE_W-1:0] near_price();
        return ($urandom_range(0, 19) == 0) ? $urandom : 32'd1000 + $urandom_range(0, 40);
    endfunction

    initial
    begin
        logic [SYM_W-1:0] sym;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_REGISTER;
        symbol = '0;
        side = 1'b0;
        stop_price = '0;
        limit_price = '0;
        quantity = '0;
        client_ref = '0;
        trader_ref = '0;
        market_price = '0;
        timestamp = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        calm = 1'b0;
        sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, unchanged price, full side, wrap of the id counter
        load_first_id({ID_W{1'b1}} - ID_W'(1));
        send_item(CMD_PRICE, 6'd0, 1'b0, '0, '0);
        send_item(CMD_REGISTER, 6'd63, 1'b1, 32'hFFFF_FFFF, '0);
        send_item(CMD_REGISTER, 6'd63, 1'b0, 32'd0, '0);
        send_item(CMD_REGISTER, 6'd63, 1'b1, 32'd5, '0);
        send_item(CMD_PRICE, 6'd63, 1'b1, '0, 32'hFFFF_FFFF);
        send_item(CMD_PRICE, 6'd63, 1'b0, '0, 32'hFFFF_FFFF);
        send_item(CMD_PRICE, 6'd63, 1'b0, '0, 32'd0);
        for (int i = 0; i < STOPS_PER_SIDE + 1; i++)
            send_item(CMD_REGISTER, 6'd5, 1'b0, 32'(100 - (i % 3)), '0);
        send_item(CMD_PRICE, 6'd5, 1'b0, '0, 32'd200);

        load_first_id('0);
        // Random: mostly registrations and price moves on a few symbols
        for (int i = 0; i < 185; i++)
        begin
            calm = (i >= 100 && i < 130);
            if (i == 70) load_first_id(ID_W'({$urandom, $urandom} >> 16));
            if (i == 140) load_first_id({ID_W{1'b1}});
            sym = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
            if ($urandom_range(0, 2) != 0)
                send_item(CMD_REGISTER, sym, 1'($urandom), near_price(), $urandom);
            else
                send_item(CMD_PRICE, sym, 1'($urandom), $urandom, near_price());
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Run covered %0d command items and %0d fired stop orders.",
                 sent, fired_total);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Overall time limit
    initial
    begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

endmodule
